// ===== sv/pairing_link_classifier_top_defines.svh =====
// ----------------------------------------------------------------------------
// Pairing link classifier assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRING_LINK_CLASSIFIER_TOP_DEFINES_SVH
`define PAIRING_LINK_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define PLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pairing link classifier check failed");

// Antecedent implies consequent in the next cycle.
`define PLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pairing link classifier check failed");

`else

`define PLC_ASSERT_NOW(label, ante, cons)
`define PLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/plc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairing link classifier package
// Field widths, command and result codes shared by the classifier.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int POS_W     = 16;  // pattern start and length
    localparam int TXT_W     = 31;  // text start
    localparam int FACTOR_W  = 10;  // factor length L
    localparam int INTRON_W  = 31;  // max_intron_len
    localparam int CFG_DATA_W = 31;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // Pattern sums fit 18 bits, text sums fit 34 bits.
    localparam int PSUM_W = POS_W + 2;
    localparam int TSUM_W = TXT_W + 3;

    localparam int LONG_FACTOR = 5;

    // Overlap test overlap > 0.4 * len done as 5 * overlap > 2 * len.
    localparam int OVL_NUM = 5;
    localparam int OVL_DEN = 2;

    localparam logic [FACTOR_W-1:0] MIN_FACTOR_RESET = 10'd15;
    localparam logic [INTRON_W-1:0] MAX_INTRON_RESET = 31'd0;

    typedef enum logic [0:0] {
        REG_MIN_FACTOR = 1'b0,
        REG_MAX_INTRON = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_STRICT = 2'd0,
        CMD_LOOSE  = 2'd1,
        CMD_SOURCE = 2'd2,
        CMD_SINK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CASE_NONE     = 3'd0,
        CASE_SP_ST    = 3'd1,
        CASE_SP_OT    = 3'd2,
        CASE_OP_ST    = 3'd3,
        CASE_OP_OT    = 3'd4,
        CASE_ORDER    = 3'd5,
        CASE_TOO_LONG = 3'd6
    } case_t;

endpackage

// ===== sv/pairing_link_classifier_top.sv =====
`timescale 1ns / 1ps
`include "pairing_link_classifier_top_defines.svh"
// ----------------------------------------------------------------------------
// Pairing link classifier
// Decides how two alignment pairings relate: strict or loose edge with its
// pattern/text case, or whether one blocks the other as source or sink.
// ----------------------------------------------------------------------------
//  channel | dir | content
//  s_*     | in  | tdata: pairings A and B, tuser: cmd, same_pairing
//  m_*     | out | tdata: related, case_code
//  cfg_*   | in  | register write, index 0 factor length L, 1 max_intron_len
//
//  An accepted item passes, in order, through one input register, one stage
//  of compares and one result register.
//  One item is accepted per cycle when the output is not stalled.
//  A stall on m_tready holds the result and, once the input register is also
//  full, drops s_tready. Reset empties both registers and loads defaults.
// ----------------------------------------------------------------------------
module pairing_link_classifier_top
    import plc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_pat_start[15:0], first_txt_start[46:16], first_len[62:47],
    // second_pat_start[78:63], second_txt_start[109:79], second_len[125:110]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cmd[1:0], same_pairing[2]
    input  logic [S_TUSER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // related[0], case_code[3:1]
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FACTOR_W-1:0] factor_len_reg;
    logic [INTRON_W-1:0] max_intron_len_reg;

    logic               in_valid_reg, in_valid_next;
    cmd_t               cmd_reg;
    logic               same_reg;
    logic [POS_W-1:0]   ap_reg, al_reg, bp_reg, bl_reg;
    logic [TXT_W-1:0]   at_reg, bt_reg;

    logic               out_valid_reg, out_valid_next;
    logic               related_reg, related_next;
    case_t              case_reg, case_next;

    logic               s_accept;
    logic               out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_len_reg     <= MIN_FACTOR_RESET;
            max_intron_len_reg <= MAX_INTRON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MIN_FACTOR: factor_len_reg <= cfg_data[FACTOR_W-1:0];
                REG_MAX_INTRON: max_intron_len_reg <= cfg_data[INTRON_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or being drained in the same cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ap_reg   <= s_tdata[15:0];
            at_reg   <= s_tdata[46:16];
            al_reg   <= s_tdata[62:47];
            bp_reg   <= s_tdata[78:63];
            bt_reg   <= s_tdata[109:79];
            bl_reg   <= s_tdata[125:110];
            cmd_reg  <= cmd_t'(s_tuser[1:0]);
            same_reg <= s_tuser[2];
        end
        if (out_load)
        begin
            related_reg <= related_next;
            case_reg    <= case_next;
        end
    end

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    logic [FACTOR_W:0]   two_l;
    logic [FACTOR_W:0]   fl;
    logic [PSUM_W-1:0]   ap_end, bp_end;
    logic [TSUM_W-1:0]   at_end, bt_end, t_tail;
    logic                p_simple, p_overlap, t_simple, t_overlap;
    logic                a_long, ovl_large;
    logic [16:0]         tail_short;
    logic [19:0]         tail_scaled;
    logic                loose_reject, disjoint, src_block, snk_block;
    case_t               edge_code;

    assign two_l  = {factor_len_reg, 1'b0};
    assign fl     = {factor_len_reg, 1'b1};
    assign ap_end = PSUM_W'(ap_reg) + PSUM_W'(al_reg);
    assign bp_end = PSUM_W'(bp_reg) + PSUM_W'(bl_reg);
    assign at_end = TSUM_W'(at_reg) + TSUM_W'(al_reg);
    assign bt_end = TSUM_W'(bt_reg) + TSUM_W'(bl_reg);

    assign p_simple  = (ap_end <= PSUM_W'(bp_reg)) &&
                       (PSUM_W'(bp_reg) <= ap_end + PSUM_W'(fl));
    assign p_overlap = (PSUM_W'(ap_reg) + PSUM_W'(two_l) <= bp_end) &&
                       (PSUM_W'(bp_reg) < ap_end);

    assign t_simple  = (at_end <= TSUM_W'(bt_reg)) &&
                       ((max_intron_len_reg == '0) ||
                        (TSUM_W'(bt_reg) <= at_end + TSUM_W'(max_intron_len_reg)));
    // B.p + A.t - A.p - B.t <= fl, rearranged to stay unsigned.
    assign t_overlap = (TSUM_W'(at_reg) + TSUM_W'(two_l) <= bt_end) &&
                       (TSUM_W'(bt_reg) < at_end) &&
                       (TSUM_W'(bp_reg) + TSUM_W'(at_reg) <=
                        TSUM_W'(fl) + TSUM_W'(ap_reg) + TSUM_W'(bt_reg));

    // Only consulted in strict mode with B.t > A.t, where the tail is
    // below A.l and fits 17 bits.
    assign t_tail      = at_end - TSUM_W'(bt_reg);
    assign tail_short  = t_tail[16:0];
    assign tail_scaled = 20'(tail_short) * 20'(OVL_NUM);
    assign ovl_large   = tail_scaled > 20'(al_reg) * 20'(OVL_DEN);
    assign a_long      = 17'(al_reg) >= 17'(LONG_FACTOR) * 17'(factor_len_reg);

    always_comb
    begin
        edge_code = CASE_NONE;
        if (p_simple)
        begin
            if (t_simple)
                edge_code = CASE_SP_ST;
            else if (t_overlap)
                edge_code = (cmd_reg == CMD_STRICT && a_long && ovl_large) ?
                            CASE_TOO_LONG : CASE_SP_OT;
        end
        else if (p_overlap)
        begin
            if (t_simple)
                edge_code = CASE_OP_ST;
            else if (t_overlap)
                edge_code = CASE_OP_OT;
        end
    end

    // Loose mode loop guard: B behind A on the pattern but inside A on the
    // text, or B not ahead of A anywhere unless at the same start and at least as long.
    assign loose_reject =
        ((bp_reg < ap_reg) && (bt_reg > at_reg) && (TSUM_W'(bt_reg) < at_end)) ||
        ((bp_reg <= ap_reg) && (bt_reg <= at_reg) &&
         ((bp_reg < ap_reg) || (bt_reg < at_reg) || (bl_reg < al_reg)));

    assign disjoint =
        ((ap_end <= PSUM_W'(bp_reg)) || (bp_end <= PSUM_W'(ap_reg))) &&
        ((at_end <= TSUM_W'(bt_reg)) || (bt_end <= TSUM_W'(at_reg)));

    assign src_block =
        (PSUM_W'(ap_reg) + PSUM_W'(factor_len_reg) <= PSUM_W'(bp_reg)) &&
        (TSUM_W'(at_reg) + TSUM_W'(factor_len_reg) <= TSUM_W'(bt_reg));

    assign snk_block =
        (ap_end + PSUM_W'(factor_len_reg) <= bp_end) &&
        (at_end + TSUM_W'(factor_len_reg) <= bt_end);

    always_comb
    begin
        case_next    = CASE_NONE;
        related_next = 1'b0;
        case (cmd_reg)
            CMD_STRICT:
            begin
                if ((bp_reg <= ap_reg) || (bt_reg <= at_reg))
                    case_next = CASE_ORDER;
                else
                    case_next = edge_code;
                related_next = case_next inside {CASE_SP_ST, CASE_SP_OT,
                                                 CASE_OP_ST, CASE_OP_OT};
            end
            CMD_LOOSE:
            begin
                if (same_reg || loose_reject)
                    case_next = CASE_ORDER;
                else
                    case_next = edge_code;
                related_next = case_next inside {CASE_SP_ST, CASE_SP_OT,
                                                 CASE_OP_ST, CASE_OP_OT};
            end
            CMD_SOURCE: related_next = disjoint || src_block;
            CMD_SINK:   related_next = disjoint || snk_block;
            default:    related_next = 1'b0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, case_reg, related_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PLC_ASSERT_NOW(a_reject_not_related, m_tvalid &&
        (m_tdata[3:1] == CASE_ORDER || m_tdata[3:1] == CASE_TOO_LONG), !m_tdata[0])
    `PLC_ASSERT_NOW(a_block_test_no_case, in_valid_reg &&
        (cmd_reg == CMD_SOURCE || cmd_reg == CMD_SINK), case_next == CASE_NONE)
    `PLC_ASSERT_NOW(a_too_long_strict_only, in_valid_reg && case_next == CASE_TOO_LONG,
        cmd_reg == CMD_STRICT)
    `PLC_ASSERT_NEXT(a_stalled_item_kept, in_valid_reg && !out_load, in_valid_reg)

endmodule

// ===== test/pairing_link_classifier_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairing link classifier testbench
// Streams pairs of pairings into the classifier and checks each related and
// case_code result against an in-bench prediction. Starts with directed
// corner cases, then runs random phases over several register settings,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module pairing_link_classifier_top_test;
    import plc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int NUM_SETTINGS    = 7;
    localparam longint PAT_MAX     = 64'd65535;
    localparam longint TXT_MAX     = 64'h7FFF_FFFF;

    typedef struct packed {
        cmd_t              cmd;
        logic [POS_W-1:0]  a_pat;
        logic [TXT_W-1:0]  a_txt;
        logic [POS_W-1:0]  a_len;
        logic [POS_W-1:0]  b_pat;
        logic [TXT_W-1:0]  b_txt;
        logic [POS_W-1:0]  b_len;
        logic              same;
    } link_item_t;

    typedef struct packed {
        logic  related;
        case_t code;
    } link_result_t;

    typedef struct {
        longint p;
        longint t;
        longint l;
    } span_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    link_item_t   pending_links[$];
    link_result_t expected_links[$];
    link_item_t   cur_item;

    logic [FACTOR_W-1:0] model_min_factor = MIN_FACTOR_RESET;
    logic [INTRON_W-1:0] model_max_intron = MAX_INTRON_RESET;

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned hold_left = 0;
    int unsigned recv_calm = 0;

    pairing_link_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic bit text_simple(span_t a, span_t b);
        longint mi;
        mi = longint'(model_max_intron);
        return (a.t + a.l <= b.t) && (mi == 0 || b.t <= a.t + a.l + mi);
    endfunction

    function automatic bit text_overlap(span_t a, span_t b);
        longint lf;
        longint fl;
        lf = longint'(model_min_factor);
        fl = 2 * lf + 1;
        return (a.t + 2 * lf <= b.t + b.l) && (b.t < a.t + a.l) &&
               (b.p + a.t - a.p - b.t <= fl);
    endfunction

    function automatic case_t edge_code(span_t a, span_t b, bit strict_mode);
        longint lf;
        longint fl;
        lf = longint'(model_min_factor);
        fl = 2 * lf + 1;
        if (a.p + a.l <= b.p && b.p <= a.p + a.l + fl)
        begin
            if (text_simple(a, b))
                return CASE_SP_ST;
            if (text_overlap(a, b))
            begin
                if (strict_mode && a.l >= LONG_FACTOR * lf &&
                    OVL_NUM * (a.t + a.l - b.t) > OVL_DEN * a.l)
                    return CASE_TOO_LONG;
                return CASE_SP_OT;
            end
            return CASE_NONE;
        end
        if (a.p + 2 * lf <= b.p + b.l && b.p < a.p + a.l)
        begin
            if (text_simple(a, b))
                return CASE_OP_ST;
            if (text_overlap(a, b))
                return CASE_OP_OT;
        end
        return CASE_NONE;
    endfunction

    function automatic bit spans_disjoint(span_t a, span_t b);
        return ((a.p + a.l <= b.p) || (b.p + b.l <= a.p)) &&
               ((a.t + a.l <= b.t) || (b.t + b.l <= a.t));
    endfunction

    function automatic link_result_t classify_link(link_item_t it);
        span_t        a;
        span_t        b;
        longint       lf;
        longint       dp;
        longint       dt;
        link_result_t r;
        a.p = longint'(it.a_pat);
        a.t = longint'(it.a_txt);
        a.l = longint'(it.a_len);
        b.p = longint'(it.b_pat);
        b.t = longint'(it.b_txt);
        b.l = longint'(it.b_len);
        lf = longint'(model_min_factor);
        dp = b.p - a.p;
        dt = b.t - a.t;
        r.related = 1'b0;
        r.code = CASE_NONE;
        case (it.cmd)
            CMD_STRICT:
            begin
                if (b.p <= a.p || b.t <= a.t)
                    r.code = CASE_ORDER;
                else
                    r.code = edge_code(a, b, 1'b1);
            end
            CMD_LOOSE:
            begin
                // A pairing may not link to itself, and steps that go back
                // along the pattern into A on the text, or ahead nowhere, are refused to avoid loops.
                if (it.same)
                    r.code = CASE_ORDER;
                else if (dp < 0 && dt > 0 && dt < a.l)
                    r.code = CASE_ORDER;
                else if (dp <= 0 && dt <= 0 && (dp < 0 || dt < 0 || b.l < a.l))
                    r.code = CASE_ORDER;
                else
                    r.code = edge_code(a, b, 1'b0);
            end
            CMD_SOURCE:
                r.related = spans_disjoint(a, b) ||
                            ((a.p + lf <= b.p) && (a.t + lf <= b.t));
            default:
                r.related = spans_disjoint(a, b) ||
                            ((a.p + a.l + lf <= b.p + b.l) &&
                             (a.t + a.l + lf <= b.t + b.l));
        endcase
        if (it.cmd == CMD_STRICT || it.cmd == CMD_LOOSE)
            r.related = (r.code >= CASE_SP_ST && r.code <= CASE_OP_OT);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic longint clip(longint v, longint top);
        return (v < 0) ? 0 : ((v > top) ? top : v);
    endfunction

    // Uniform value in [-down, up].
    function automatic longint rnd_off(longint up, longint down);
        return longint'($urandom_range(0, 32'(up + down))) - down;
    endfunction

    function automatic void queue_pairs(cmd_t cmd, longint ap, longint at, longint al,
                                        longint bp, longint bt, longint bl, bit same);
        link_item_t it;
        it.cmd   = cmd;
        it.a_pat = 16'(clip(ap, PAT_MAX));
        it.a_txt = 31'(clip(at, TXT_MAX));
        it.a_len = 16'(clip(al, PAT_MAX));
        it.b_pat = 16'(clip(bp, PAT_MAX));
        it.b_txt = 31'(clip(bt, TXT_MAX));
        it.b_len = 16'(clip(bl, PAT_MAX));
        it.same  = same;
        pending_links.push_back(it);
    endfunction

    function automatic void queue_random_pair();
        longint lf;
        longint fl;
        longint ap;
        longint at;
        longint al;
        longint bp;
        longint bt;
        longint bl;
        longint lo;
        longint hi;
        int unsigned kind;
        cmd_t cmd;
        bit same;
        link_item_t it;
        lf = longint'(model_min_factor);
        fl = 2 * lf + 1;
        kind = $urandom_range(0, 99);
        cmd = cmd_t'(2'($urandom_range(0, 3)));
        same = ($urandom_range(0, 9) == 0);
        if (kind < 15)
        begin
            // Unstructured noise reaches every bit of every field.
            it.cmd   = cmd;
            it.a_pat = 16'($urandom);
            it.a_txt = 31'($urandom);
            it.a_len = 16'($urandom);
            it.b_pat = 16'($urandom);
            it.b_txt = 31'($urandom);
            it.b_len = 16'($urandom);
            it.same  = 1'($urandom);
            pending_links.push_back(it);
            return;
        end
        ap = ($urandom_range(0, 7) == 0) ? PAT_MAX - $urandom_range(0, 3000)
                                         : longint'($urandom_range(0, 50000));
        case ($urandom_range(0, 7))
            0: at = TXT_MAX - $urandom_range(0, 200000);
            1: at = longint'($urandom_range(0, 5000));
            default: at = longint'($urandom_range(0, 32'h4000_0000));
        endcase
        if (kind < 80)
        begin
            // B placed near the end of A so that the edge conditions sit
            // close to their boundaries.
            al = longint'($urandom_range(0, 32'(6 * lf + 8)));
            if ($urandom_range(0, 3) == 0)
                bp = ap + rnd_off(4, 4);
            else
                bp = ap + al + rnd_off(2 * lf + 4, al + 2 * lf + 3);
            case ($urandom_range(0, 3))
                0: bt = at + (bp - ap) + rnd_off(fl + 2, fl + 2);
                1: bt = at + al + rnd_off(2 * lf + 4, al + 2 * lf + 3);
                2: bt = at + al + longint'(model_max_intron) + rnd_off(1, 1);
                default: bt = at + rnd_off(2 * lf + 4, 2 * lf + 4);
            endcase
            if ($urandom_range(0, 3) == 0)
                bl = longint'($urandom_range(0, 32'(al)));
            else
                bl = al + rnd_off(2 * lf + 4, 2 * lf + 2);
        end
        else if (kind < 92)
        begin
            // Long A with a text overlap around four tenths of its length.
            al = 5 * lf + $urandom_range(0, 32'(3 * lf + 3));
            bp = ap + al + $urandom_range(0, 2);
            lo = al - fl - 2;
            hi = (3 * al) / 5 + 2;
            if (hi < lo)
                hi = lo;
            bt = at + lo + longint'($urandom_range(0, 32'(hi - lo)));
            bl = 2 * lf + $urandom_range(0, 40);
        end
        else
        begin
            // B equal to A, or off by one in a single field.
            al = longint'($urandom_range(0, 32'(4 * lf + 8)));
            bp = ap;
            bt = at;
            bl = al;
            case ($urandom_range(0, 5))
                0: bp = ap + rnd_off(1, 1);
                1: bt = at + rnd_off(1, 1);
                2: bl = al + rnd_off(1, 1);
                default: ;
            endcase
        end
        queue_pairs(cmd, ap, at, al, bp, bt, bl, same);
    endfunction

    function automatic void queue_directed_pairs();
        // Extremes of every field under each command.
        for (int c = 0; c < 4; c++)
        begin
            queue_pairs(cmd_t'(2'(c)), 0, 0, 0, 0, 0, 0, 1'b0);
            queue_pairs(cmd_t'(2'(c)), PAT_MAX, TXT_MAX, PAT_MAX,
                        PAT_MAX, TXT_MAX, PAT_MAX, 1'b1);
        end
        // Each edge case on pattern and text, with the default L of 15.
        queue_pairs(CMD_STRICT, 100, 100, 20, 120, 120, 20, 1'b0);
        queue_pairs(CMD_STRICT, 100, 100, 40, 140, 130, 40, 1'b0);
        queue_pairs(CMD_STRICT, 100, 100, 40, 130, 140, 40, 1'b0);
        queue_pairs(CMD_STRICT, 100, 100, 40, 130, 130, 40, 1'b0);
        // Strict order reject and overlap too large.
        queue_pairs(CMD_STRICT, 100, 100, 40, 100, 200, 40, 1'b0);
        queue_pairs(CMD_STRICT, 100, 1000, 76, 176, 1045, 40, 1'b0);
        queue_pairs(CMD_LOOSE, 100, 1000, 76, 176, 1045, 40, 1'b0);
        // Simple on pattern, neither case on text.
        queue_pairs(CMD_STRICT, 100, 100, 20, 120, 101, 5, 1'b0);
        // Loose edge: same object and the loop guards.
        queue_pairs(CMD_LOOSE, 100, 100, 40, 100, 100, 40, 1'b1);
        queue_pairs(CMD_LOOSE, 100, 100, 40, 90, 120, 40, 1'b0);
        queue_pairs(CMD_LOOSE, 100, 100, 40, 100, 100, 30, 1'b0);
        // Blocking tests, true and false, disjoint and shifted.
        queue_pairs(CMD_SOURCE, 100, 100, 40, 115, 115, 40, 1'b0);
        queue_pairs(CMD_SOURCE, 100, 100, 40, 110, 115, 40, 1'b0);
        queue_pairs(CMD_SINK, 100, 100, 40, 110, 110, 45, 1'b0);
        queue_pairs(CMD_SINK, 100, 100, 40, 110, 110, 44, 1'b0);
        queue_pairs(CMD_SOURCE, 100, 100, 10, 200, 50, 10, 1'b0);
        // Text sums past 31 bits.
        queue_pairs(CMD_STRICT, 0, TXT_MAX - 15, PAT_MAX, PAT_MAX, TXT_MAX, PAT_MAX, 1'b0);
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int unsigned pick_gap(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(30, 150);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_links.push_back(classify_link(cur_item));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_links.size() > 0)
                begin
                    cur_item = pending_links.pop_front();
                    s_tdata  <= {2'b00, cur_item.b_len, cur_item.b_txt, cur_item.b_pat,
                                 cur_item.a_len, cur_item.a_txt, cur_item.a_pat};
                    s_tuser  <= {cur_item.same, cur_item.cmd};
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_proc
        link_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_links.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: related=%0d case_code=%0d",
                                 m_tdata[0], m_tdata[3:1]);
                end
                else
                begin
                    want = expected_links.pop_front();
                    if (m_tdata[0] !== want.related || m_tdata[3:1] !== want.code)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected related/case %0d/%0d, got %0d/%0d",
                                     want.related, want.code, m_tdata[0], m_tdata[3:1]);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                hold_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_MIN_FACTOR)
            model_min_factor = value[FACTOR_W-1:0];
        else
            model_max_intron = value[INTRON_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_links.size() > 0 || s_tvalid || expected_links.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [FACTOR_W-1:0] factor_set[NUM_SETTINGS];
        logic [INTRON_W-1:0] intron_set[NUM_SETTINGS];
        logic [CFG_DATA_W-1:0] upper;
        factor_set = '{10'd0, 10'd1, 10'd1023, 10'($urandom_range(2, 60)), 10'd15,
                       10'd2, 10'($urandom)};
        intron_set = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'($urandom_range(0, 200)), 31'd40,
                       31'd0, 31'($urandom)};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults from reset.
        queue_directed_pairs();
        for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_pair();
        wait_idle();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            // Bits above the register width are filled at random.
            upper = 31'($urandom) & ~31'h3FF;
            write_reg(REG_MIN_FACTOR, upper | 31'(factor_set[s]));
            write_reg(REG_MAX_INTRON, intron_set[s]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                queue_random_pair();
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_links.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== pairing_link_classifier_top.f =====
+incdir+sv
sv/plc_pkg.sv
sv/pairing_link_classifier_top.sv
test/pairing_link_classifier_top_test.sv
